/* rtl/gbmh_pkg.sv */
// ----------------------------------------------------------------------------
// gbmh_pkg
// Shared types and constants for the geometric-bin magnitude histogram.
// ----------------------------------------------------------------------------
package gbmh_pkg;

	localparam int MAX_BINS = 16;
	localparam int BIN_W    = 5;                 // holds 0..MAX_BINS+2
	localparam int LIM_W    = $clog2(MAX_BINS);  // limit table index
	localparam int CFG_W    = 2;

	localparam logic [31:0] Q_ONE = 32'h0001_0000;

	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [CFG_W-1:0] CFG_MIN_LIMIT    = 2'd0;
	localparam logic [CFG_W-1:0] CFG_GROWTH_RATIO = 2'd1;
	localparam logic [CFG_W-1:0] CFG_BIN_COUNT    = 2'd2;

	localparam logic [BIN_W-1:0] HIT_ZERO = BIN_W'(MAX_BINS + 1);
	localparam logic [BIN_W-1:0] HIT_ONE  = BIN_W'(MAX_BINS + 2);

	typedef struct packed {
		logic [1:0]        op;
		logic signed [31:0] value;
		logic [4:0]        bin_index;
	} req_t;

	typedef struct packed {
		logic [4:0]  bin_hit;
		logic [31:0] bin_total;
		logic [31:0] zero_total;
		logic [31:0] one_total;
		logic [31:0] min_magnitude_seen;
		logic [31:0] max_magnitude_seen;
	} rsp_t;

	typedef struct packed {
		logic load;        // latch accepted item
		logic walk_step;   // compare against next limit
		logic bump;        // update counter and extremes
		logic build_step;  // write one limit, advance product
		logic emit;        // load output register
	} cmd_t;

	typedef struct packed {
		logic walk_done;
		logic build_last;
	} stat_t;

endpackage

/* rtl/gbmh_ctrl.sv */
// ----------------------------------------------------------------------------
// gbmh_ctrl
// Sequencer: accepts one item at a time and steps the datapath through the
// limit walk, counter update, limit rebuild and result hand-off.
// ----------------------------------------------------------------------------
module gbmh_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic [1:0]       req_op,
	output logic             req_ready,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	input  gbmh_pkg::stat_t  stat,
	output gbmh_pkg::cmd_t   cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_WALK  = 5'b00010,
		ST_BUMP  = 5'b00100,
		ST_BUILD = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   slot_free;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign slot_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					case (req_op)
						gbmh_pkg::OP_SAMPLE: state_d = ST_WALK;
						gbmh_pkg::OP_CLEAR:  state_d = ST_BUILD;
						default:             state_d = ST_EMIT;
					endcase
				end
			end
			ST_WALK: begin
				if (stat.walk_done) begin
					state_d = ST_BUMP;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			ST_BUMP: begin
				cmd.bump = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_BUILD: begin
				cmd.build_step = 1'b1;
				if (stat.build_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				// hold until the output register is free
				if (slot_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/gbmh_dp.sv */
// ----------------------------------------------------------------------------
// gbmh_dp
// Datapath: configuration registers, limit table, bin counters, extremes,
// one limit comparator, one limit multiplier and the output register.
// ----------------------------------------------------------------------------
module gbmh_dp #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [gbmh_pkg::CFG_W-1:0]     cfg_addr,
	input  logic [31:0]                    cfg_wdata,
	input  gbmh_pkg::req_t                 req,
	input  gbmh_pkg::cmd_t                 cmd,
	output gbmh_pkg::stat_t                stat,
	output gbmh_pkg::rsp_t                 rsp
);

	localparam int BW = gbmh_pkg::BIN_W;
	localparam int LW = gbmh_pkg::LIM_W;
	localparam int NB = gbmh_pkg::MAX_BINS;

	logic [31:0]            min_limit_q;
	logic [15:0]            growth_ratio_q;
	logic [4:0]             bin_count_q;

	logic [31:0]            limits_q [0:NB-1];
	logic [COUNT_WIDTH-1:0] counts_q [0:NB];
	logic [COUNT_WIDTH-1:0] zero_cnt_q, one_cnt_q;
	logic [31:0]            min_mag_q, max_mag_q;

	logic [1:0]             op_q;
	logic [31:0]            mag_q;
	logic [4:0]             bidx_q;
	logic [BW-1:0]          idx_q;
	logic [BW-1:0]          hit_q;
	logic [31:0]            lim_q;
	gbmh_pkg::rsp_t         rsp_q;

	logic [31:0]            mag_in;
	logic [BW-1:0]          n_active;
	logic                   is_zero, is_one;
	logic [47:0]            prod;
	logic [31:0]            next_lim;
	logic [BW-1:0]          cnt_addr;
	logic [COUNT_WIDTH-1:0] cnt_rd;
	logic [COUNT_WIDTH-1:0] cnt_inc;
	logic [63:0]            zero_ext, one_ext, total_ext;

	assign mag_in = req.value[31] ? (32'd0 - req.value) : req.value;
	assign is_zero = (mag_q == 32'd0);
	assign is_one  = (mag_q == gbmh_pkg::Q_ONE);

	always_comb begin
		if (bin_count_q == 5'd0) begin
			n_active = BW'(1);
		end else if (bin_count_q > 5'(NB)) begin
			n_active = BW'(NB);
		end else begin
			n_active = BW'(bin_count_q);
		end
	end

	// walk ends on a special magnitude, past the last active limit, or on
	// the first limit that exceeds the magnitude
	always_comb begin
		stat.walk_done  = is_zero || is_one || (idx_q >= n_active) ||
			(mag_q < limits_q[idx_q[LW-1:0]]);
		stat.build_last = (idx_q == BW'(NB - 1));
	end

	assign prod     = 48'(lim_q) * 48'(growth_ratio_q);
	assign next_lim = (|prod[47:40]) ? 32'hFFFF_FFFF : prod[39:8];

	// single counter read port, shared by the update and the read-out
	assign cnt_addr = cmd.bump ? idx_q : BW'(bidx_q);
	assign cnt_rd   = (cnt_addr <= BW'(NB)) ? counts_q[cnt_addr] : '0;
	assign cnt_inc  = (&cnt_rd) ? cnt_rd : cnt_rd + COUNT_WIDTH'(1);

	assign zero_ext  = 64'(zero_cnt_q);
	assign one_ext   = 64'(one_cnt_q);
	assign total_ext = 64'(cnt_rd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_limit_q    <= 32'h0001_0000;
			growth_ratio_q <= 16'h0A00;
			bin_count_q    <= 5'd8;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				gbmh_pkg::CFG_MIN_LIMIT:    min_limit_q    <= cfg_wdata;
				gbmh_pkg::CFG_GROWTH_RATIO: growth_ratio_q <= cfg_wdata[15:0];
				gbmh_pkg::CFG_BIN_COUNT:    bin_count_q    <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NB; i++) begin
				limits_q[i] <= 32'hFFFF_FFFF;
			end
			for (int i = 0; i <= NB; i++) begin
				counts_q[i] <= '0;
			end
			zero_cnt_q <= '0;
			one_cnt_q  <= '0;
			min_mag_q  <= 32'hFFFF_FFFF;
			max_mag_q  <= 32'd0;
		end else begin
			if (cmd.load && req.op == gbmh_pkg::OP_CLEAR) begin
				for (int i = 0; i <= NB; i++) begin
					counts_q[i] <= '0;
				end
				zero_cnt_q <= '0;
				one_cnt_q  <= '0;
				min_mag_q  <= 32'hFFFF_FFFF;
				max_mag_q  <= 32'd0;
			end
			if (cmd.build_step) begin
				limits_q[idx_q[LW-1:0]] <= lim_q;
			end
			if (cmd.bump) begin
				if (mag_q < min_mag_q) begin
					min_mag_q <= mag_q;
				end
				if (mag_q > max_mag_q) begin
					max_mag_q <= mag_q;
				end
				if (is_zero) begin
					zero_cnt_q <= (&zero_cnt_q) ? zero_cnt_q :
						zero_cnt_q + COUNT_WIDTH'(1);
				end else if (is_one) begin
					one_cnt_q <= (&one_cnt_q) ? one_cnt_q :
						one_cnt_q + COUNT_WIDTH'(1);
				end else begin
					counts_q[idx_q] <= cnt_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= req.op;
			mag_q  <= mag_in;
			bidx_q <= req.bin_index;
			idx_q  <= '0;
			hit_q  <= '0;
			lim_q  <= min_limit_q;
		end
		if (cmd.walk_step || cmd.build_step) begin
			idx_q <= idx_q + BW'(1);
		end
		if (cmd.build_step) begin
			lim_q <= next_lim;
		end
		if (cmd.bump) begin
			if (is_zero) begin
				hit_q <= gbmh_pkg::HIT_ZERO;
			end else if (is_one) begin
				hit_q <= gbmh_pkg::HIT_ONE;
			end else begin
				hit_q <= idx_q;
			end
		end
		if (cmd.emit) begin
			rsp_q.bin_hit            <= 5'(hit_q);
			rsp_q.bin_total          <= (op_q == gbmh_pkg::OP_READ) ? total_ext[31:0] : 32'd0;
			rsp_q.zero_total         <= zero_ext[31:0];
			rsp_q.one_total          <= one_ext[31:0];
			rsp_q.min_magnitude_seen <= min_mag_q;
			rsp_q.max_magnitude_seen <= max_mag_q;
		end
	end

	assign rsp = rsp_q;

endmodule

/* rtl/geometric_bin_magnitude_histogram_top.sv */
// ----------------------------------------------------------------------------
// geometric_bin_magnitude_histogram_top
// Magnitude histogram over geometrically spaced bins with zero/one counters,
// running extremes, bin read-out and limit rebuild on clear.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  req      in         req_valid/req_ready   gbmh_pkg::req_t (op, value, bin_index)
//  rsp      out        rsp_valid/rsp_ready   gbmh_pkg::rsp_t (six result fields)
//  cfg      in         cfg_wr_en             cfg_addr, cfg_wdata (write only)
//
// One item at a time. A sample compares its magnitude against the limits in turn
// (one limit comparison per cycle), then does a counter read-modify-write; read
// and unused ops go straight to the result; a clear rebuilds every limit, one
// limit per cycle through one multiplier.
// Reset loads the default configuration, all-ones limits and zero counters.
// A stalled rsp holds the result; the next item is still taken meanwhile.
// ----------------------------------------------------------------------------
module geometric_bin_magnitude_histogram_top #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  gbmh_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output gbmh_pkg::rsp_t              rsp,
	input  logic                        cfg_wr_en,
	input  logic [gbmh_pkg::CFG_W-1:0]  cfg_addr,
	input  logic [31:0]                 cfg_wdata
);

	gbmh_pkg::cmd_t  cmd;
	gbmh_pkg::stat_t stat;

	gbmh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req.op),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	gbmh_dp #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (rsp)
	);

	// an accepted item always keeps the block busy for the next cycle
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("req_ready high right after a transfer");

	a_hit_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.bin_hit <= gbmh_pkg::HIT_ONE)
		else $error("bin_hit out of range");

	// once any nonzero sample is seen the extremes are ordered
	a_extremes_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.max_magnitude_seen != 32'd0 |->
			rsp.min_magnitude_seen <= rsp.max_magnitude_seen)
		else $error("min magnitude above max magnitude");

	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.walk_step, cmd.bump, cmd.build_step, cmd.emit}))
		else $error("more than one datapath command");

endmodule
